// ----- hdl/rodt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rodt_pkg
// Shared types, register map and counting unit codes of the off-delay timer.
// ----------------------------------------------------------------------------
package rodt_pkg;

	localparam int unsigned CountW  = 16;
	localparam int unsigned MinuteW = 6;
	localparam int unsigned SecondW = 6;
	localparam int unsigned TenthW  = 4;
	localparam int unsigned UnitW   = 2;
	localparam int unsigned AddrW   = 3;
	localparam int unsigned DataW   = 32;

	// register index, taken from paddr[2]
	localparam logic REG_PRESET = 1'b0;
	localparam logic REG_UNIT   = 1'b1;

	localparam logic [UnitW-1:0] UNIT_TENTHS  = 2'd0;
	localparam logic [UnitW-1:0] UNIT_SECONDS = 2'd1;
	localparam logic [UnitW-1:0] UNIT_MINUTES = 2'd2;
	localparam logic [UnitW-1:0] UNIT_HOURS   = 2'd3;

	localparam logic FUNC_EVALUATE = 1'b0;
	localparam logic FUNC_TICK     = 1'b1;

	typedef logic [CountW-1:0]  count_t;
	typedef logic [MinuteW-1:0] minute_t;
	typedef logic [SecondW-1:0] second_t;
	typedef logic [TenthW-1:0]  tenth_t;
	typedef logic [UnitW-1:0]   unit_t;

	typedef struct packed {
		count_t preset_time;
		unit_t  unit_mode;
	} cfg_t;

endpackage
`default_nettype wire

// ----- hdl/rodt_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rodt_in_if
// Input channel: evaluate and tick items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rodt_in_if;
	logic                valid;
	logic                ready;
	logic                func;
	logic                input_level;
	rodt_pkg::count_t    tick_increment;
	rodt_pkg::minute_t   clock_minute;
	rodt_pkg::second_t   clock_second;
	rodt_pkg::tenth_t    clock_tenth;

	modport source (
		output valid, func, input_level, tick_increment,
		       clock_minute, clock_second, clock_tenth,
		input  ready
	);
	modport sink (
		input  valid, func, input_level, tick_increment,
		       clock_minute, clock_second, clock_tenth,
		output ready
	);
endinterface
`default_nettype wire

// ----- hdl/rodt_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rodt_out_if
// Result channel: output level and elapsed count with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rodt_out_if;
	logic             valid;
	logic             ready;
	logic             output_level;
	rodt_pkg::count_t elapsed_count;

	modport source (
		output valid, output_level, elapsed_count,
		input  ready
	);
	modport sink (
		input  valid, output_level, elapsed_count,
		output ready
	);
endinterface
`default_nettype wire

// ----- hdl/rodt_apb_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rodt_apb_regs
// APB-style register file holding the preset and the counting unit.
// ----------------------------------------------------------------------------
module rodt_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rodt_pkg::AddrW-1:0]  paddr,
	input  wire logic [rodt_pkg::DataW-1:0]  pwdata,
	output      logic [rodt_pkg::DataW-1:0]  prdata,
	output      logic                        pready,
	output      rodt_pkg::cfg_t              cfg
);

	rodt_pkg::count_t preset_q;
	rodt_pkg::unit_t  unit_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= '0;
			unit_q   <= rodt_pkg::UNIT_TENTHS;
		end else if (wr_en) begin
			case (paddr[2])
				rodt_pkg::REG_PRESET: preset_q <= pwdata[rodt_pkg::CountW-1:0];
				rodt_pkg::REG_UNIT:   unit_q   <= pwdata[rodt_pkg::UnitW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rodt_pkg::REG_PRESET: prdata = {{(rodt_pkg::DataW-rodt_pkg::CountW){1'b0}}, preset_q};
			rodt_pkg::REG_UNIT:   prdata = {{(rodt_pkg::DataW-rodt_pkg::UnitW){1'b0}}, unit_q};
			default:              prdata = '0;
		endcase
	end

	assign cfg.preset_time = preset_q;
	assign cfg.unit_mode   = unit_q;

endmodule
`default_nettype wire

// ----- hdl/rodt_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rodt_timer
// Input register, timer state update and result register.
// ----------------------------------------------------------------------------
module rodt_timer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire rodt_pkg::cfg_t cfg,
	rodt_in_if.sink         in_ch,
	rodt_out_if.source      out_ch
);

	// input stage
	logic              valid_s1;
	logic              func_s1;
	logic              level_s1;
	rodt_pkg::count_t  inc_s1;
	rodt_pkg::minute_t minute_s1;
	rodt_pkg::second_t second_s1;
	rodt_pkg::tenth_t  tenth_s1;

	// result stage
	logic              valid_s2;
	logic              out_level_s2;
	rodt_pkg::count_t  count_s2;

	// timer state
	logic              active_q;
	rodt_pkg::count_t  elapsed_q;
	rodt_pkg::minute_t start_minute_q;
	rodt_pkg::second_t start_second_q;
	rodt_pkg::tenth_t  start_tenth_q;

	logic              advance;
	logic              fire;
	logic              boundary;
	logic [rodt_pkg::CountW:0] sum;
	rodt_pkg::count_t  sat_sum;
	logic              active_d;
	rodt_pkg::count_t  elapsed_d;
	logic              snap;

	assign advance     = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign fire        = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			func_s1   <= in_ch.func;
			level_s1  <= in_ch.input_level;
			inc_s1    <= in_ch.tick_increment;
			minute_s1 <= in_ch.clock_minute;
			second_s1 <= in_ch.clock_second;
			tenth_s1  <= in_ch.clock_tenth;
		end
	end

	always_comb begin
		case (cfg.unit_mode)
			rodt_pkg::UNIT_TENTHS:  boundary = 1'b1;
			rodt_pkg::UNIT_SECONDS: boundary = (tenth_s1 == start_tenth_q);
			rodt_pkg::UNIT_MINUTES: boundary = (tenth_s1 == start_tenth_q)
			                                && (second_s1 == start_second_q);
			default:                boundary = (tenth_s1 == start_tenth_q)
			                                && (second_s1 == start_second_q)
			                                && (minute_s1 == start_minute_q);
		endcase
	end

	assign sum     = {1'b0, elapsed_q} + {1'b0, inc_s1};
	// saturate at full scale
	assign sat_sum = sum[rodt_pkg::CountW] ? '1 : sum[rodt_pkg::CountW-1:0];

	always_comb begin
		active_d  = active_q;
		elapsed_d = elapsed_q;
		snap      = 1'b0;
		if (func_s1 == rodt_pkg::FUNC_EVALUATE) begin
			if (level_s1 && !active_q) begin
				active_d  = 1'b1;
				elapsed_d = '0;
			end
		end else if (active_q) begin
			if (level_s1) begin
				// retrigger: restart the count and take a clock snapshot
				elapsed_d = '0;
				snap      = 1'b1;
			end else if (boundary) begin
				elapsed_d = sat_sum;
				if (sat_sum >= cfg.preset_time) begin
					active_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			elapsed_q      <= '0;
			start_minute_q <= '0;
			start_second_q <= '0;
			start_tenth_q  <= '0;
		end else if (fire) begin
			active_q  <= active_d;
			elapsed_q <= elapsed_d;
			if (snap) begin
				start_minute_q <= minute_s1;
				start_second_q <= second_s1;
				start_tenth_q  <= tenth_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_level_s2 <= active_d;
			count_s2     <= elapsed_d;
		end
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.output_level  = out_level_s2;
	assign out_ch.elapsed_count = count_s2;

endmodule
`default_nettype wire

// ----- hdl/retriggerable_off_delay_timer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// retriggerable_off_delay_timer_core
// Retriggerable off-delay timer with selectable counting unit.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// in_ch    in   valid/ready            func, input_level, tick_increment, clock
// out_ch   out  valid/ready            output_level, elapsed_count
// apb      in   psel/penable, pready=1 preset_time @0x0, unit_mode @0x4
//
// One item per cycle while the result side takes its results; a result passes
// through the input register and then the result register before it is offered.
// The input register and the result register part the two sides: while a
// result waits, one more transaction is taken and then the input holds.
// Reset clears the timer state and the stage valids at once, but not the data in both registers.
// ----------------------------------------------------------------------------
module retriggerable_off_delay_timer_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	rodt_in_if.sink                         in_ch,
	rodt_out_if.source                      out_ch,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rodt_pkg::AddrW-1:0] paddr,
	input  wire logic [rodt_pkg::DataW-1:0] pwdata,
	output      logic [rodt_pkg::DataW-1:0] prdata,
	output      logic                       pready
);

	rodt_pkg::cfg_t cfg;

	rodt_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rodt_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire

// ----- sim/retriggerable_off_delay_timer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retriggerable_off_delay_timer_core_test
// Drives evaluate and tick items into the off-delay timer, with random gaps on
// the input side and random back-pressure on the result side. Every result is
// checked against a local timer predictor, or against the value a table row gives. A short table covers the corner
// cases; ten random phases follow, each with its own preset and counting unit.
// Registers are written and read back over APB only while nothing is in flight.
// ----------------------------------------------------------------------------
module retriggerable_off_delay_timer_core_test;
	import rodt_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_ITEMS   = 150;
	localparam int PHASE_COUNT   = 10;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic    func;
		logic    level;
		count_t  inc;
		minute_t minute;
		second_t sec;
		tenth_t  tenth;
	} timer_item_t;

	typedef struct packed {
		logic   level;
		count_t count;
	} timer_result_t;

	typedef struct packed {
		logic          is_cfg;
		count_t        preset;
		unit_t         unit;
		timer_item_t   item;
		logic          known;
		timer_result_t want;
	} dir_row_t;

	typedef enum {GEN_ARM, GEN_RETRIG, GEN_RUN} gen_step_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [AddrW-1:0]    paddr;
	logic [DataW-1:0]    pwdata;
	logic [DataW-1:0]    prdata;
	logic                pready;

	rodt_in_if  in_ch ();
	rodt_out_if out_ch ();

	// predictor state and shadow registers
	logic          tmr_on     = 1'b0;
	count_t        tmr_count  = '0;
	minute_t       snap_min   = '0;
	second_t       snap_sec   = '0;
	tenth_t        snap_tenth = '0;
	count_t        cfg_preset = '0;
	unit_t         cfg_unit   = UNIT_TENTHS;

	timer_result_t expected_q[$];
	dir_row_t      dir_rows[$];

	logic          typed_known;
	timer_result_t typed_want;
	logic          calm = 1'b0;

	// random sequence generator state
	gen_step_t     gen_step = GEN_ARM;
	int            gen_left = 0;
	minute_t       gen_min  = '0;
	second_t       gen_sec  = '0;
	tenth_t        gen_tenth = '0;

	int            mismatches    = 0;
	int            items_sent    = 0;
	int            results_seen  = 0;
	int            reg_writes    = 0;
	int            cycle_count   = 0;
	int            dir_items     = 0;

	retriggerable_off_delay_timer_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic timer_result_t step_timer(timer_item_t it);
		logic          hit;
		logic [16:0]   sum;
		timer_result_t res;
		if (it.func == FUNC_EVALUATE) begin
			if (it.level && !tmr_on) begin
				tmr_count = '0;
				tmr_on    = 1'b1;
			end
		end else if (tmr_on) begin
			if (it.level) begin
				// retrigger: clear and take a fresh snapshot of the clock
				tmr_count  = '0;
				snap_min   = it.minute;
				snap_sec   = it.sec;
				snap_tenth = it.tenth;
			end else begin
				case (cfg_unit)
					UNIT_TENTHS:  hit = 1'b1;
					UNIT_SECONDS: hit = (it.tenth == snap_tenth);
					UNIT_MINUTES: hit = (it.tenth == snap_tenth) && (it.sec == snap_sec);
					default:      hit = (it.tenth == snap_tenth) && (it.sec == snap_sec)
					                    && (it.minute == snap_min);
				endcase
				if (hit) begin
					sum       = {1'b0, tmr_count} + {1'b0, it.inc};
					tmr_count = sum[16] ? '1 : sum[15:0];
					if (tmr_count >= cfg_preset)
						tmr_on = 1'b0;
				end
			end
		end
		res.level = tmr_on;
		res.count = tmr_count;
		return res;
	endfunction

	function automatic void add_cfg(count_t pr, unit_t un);
		dir_row_t r;
		r        = '0;
		r.is_cfg = 1'b1;
		r.preset = pr;
		r.unit   = un;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_item(logic fn, logic lv, count_t inc, minute_t mi, second_t se,
	                                 tenth_t te, logic kn, logic wl, count_t wc);
		dir_row_t r;
		r            = '0;
		r.item       = '{func: fn, level: lv, inc: inc, minute: mi, sec: se, tenth: te};
		r.known      = kn;
		r.want.level = wl;
		r.want.count = wc;
		dir_rows.push_back(r);
	endfunction

	function automatic count_t pick_increment();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '1;
		if (r < 16)
			return '0;
		if (r < 28)
			return count_t'($urandom);
		return count_t'($urandom_range(0, int'(cfg_preset) / 3 + 1));
	endfunction

	function automatic timer_item_t next_random_item();
		timer_item_t it;
		it.func  = FUNC_TICK;
		it.level = 1'b0;
		it.inc   = pick_increment();
		if ($urandom_range(0, 99) < 5) begin
			it.minute = minute_t'($urandom_range(0, 63));
			it.sec    = second_t'($urandom_range(0, 63));
			it.tenth  = tenth_t'($urandom_range(0, 15));
		end else begin
			it.minute = minute_t'($urandom_range(0, 59));
			it.sec    = second_t'($urandom_range(0, 59));
			it.tenth  = tenth_t'($urandom_range(0, 9));
		end
		// noise: anything at all
		if ($urandom_range(0, 99) < 12) begin
			it.func  = logic'($urandom_range(0, 1));
			it.level = logic'($urandom_range(0, 1));
			return it;
		end
		case (gen_step)
			GEN_ARM: begin
				it.func  = FUNC_EVALUATE;
				it.level = ($urandom_range(0, 99) < 90);
				gen_step = GEN_RETRIG;
				gen_left = $urandom_range(1, 2);
			end
			GEN_RETRIG: begin
				it.level  = 1'b1;
				gen_min   = it.minute;
				gen_sec   = it.sec;
				gen_tenth = it.tenth;
				gen_left--;
				if (gen_left == 0) begin
					gen_step = GEN_RUN;
					gen_left = $urandom_range(3, 20);
				end
			end
			default: begin
				if ($urandom_range(0, 99) < 75)
					it.tenth = gen_tenth;
				if ($urandom_range(0, 99) < 75)
					it.sec = gen_sec;
				if ($urandom_range(0, 99) < 75)
					it.minute = gen_min;
				if ($urandom_range(0, 99) < 5) begin
					it.level  = 1'b1;
					gen_min   = it.minute;
					gen_sec   = it.sec;
					gen_tenth = it.tenth;
				end else if ($urandom_range(0, 99) < 4) begin
					it.func  = FUNC_EVALUATE;
					it.level = logic'($urandom_range(0, 1));
				end
				gen_left--;
				if (gen_left == 0)
					gen_step = GEN_ARM;
			end
		endcase
		return it;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic send_item(input timer_item_t it, input logic known, input timer_result_t want);
		while (!calm && $urandom_range(0, 99) < 33) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		typed_known = known;
		typed_want  = want;
		in_ch.valid          <= 1'b1;
		in_ch.func           <= it.func;
		in_ch.input_level    <= it.level;
		in_ch.tick_increment <= it.inc;
		in_ch.clock_minute   <= it.minute;
		in_ch.clock_second   <= it.sec;
		in_ch.clock_tenth    <= it.tenth;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(input logic idx, input count_t val);
		logic ok;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= DataW'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_PRESET)
			cfg_preset = val;
		else
			cfg_unit = unit_t'(val);
		reg_writes++;
		// read back through a second transfer
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_PRESET)
			ok = (prdata[CountW-1:0] === val);
		else
			ok = (prdata[UnitW-1:0] === val[UnitW-1:0]);
		if (!ok)
			note_mismatch($sformatf("read back of register %0d: expected %h got %h",
			                        idx, val, prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_cfg(input count_t pr, input unit_t un);
		wait_drain();
		reg_write(REG_PRESET, pr);
		reg_write(REG_UNIT, count_t'(un));
	endtask

	// predict on every accepted item
	always @(posedge clk) begin : take_item
		timer_item_t   seen;
		timer_result_t next;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			seen.func   = in_ch.func;
			seen.level  = in_ch.input_level;
			seen.inc    = in_ch.tick_increment;
			seen.minute = in_ch.clock_minute;
			seen.sec    = in_ch.clock_second;
			seen.tenth  = in_ch.clock_tenth;
			next = step_timer(seen);
			expected_q.push_back(typed_known ? typed_want : next);
		end
	end

	always @(posedge clk) begin : check_result
		timer_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				note_mismatch($sformatf("unexpected result: level %0b count %h",
				                        out_ch.output_level, out_ch.elapsed_count));
			end else begin
				want = expected_q.pop_front();
				if (out_ch.output_level !== want.level)
					note_mismatch($sformatf("output_level: expected %0b got %0b",
					                        want.level, out_ch.output_level));
				if (out_ch.elapsed_count !== want.count)
					note_mismatch($sformatf("elapsed_count: expected %h got %h",
					                        want.count, out_ch.elapsed_count));
			end
		end
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
			         cycle_count, expected_q.size());
			$display("retriggerable_off_delay_timer_core_test: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		count_t pr;
		arst_n               = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.func           = FUNC_EVALUATE;
		in_ch.input_level    = 1'b0;
		in_ch.tick_increment = '0;
		in_ch.clock_minute   = '0;
		in_ch.clock_second   = '0;
		in_ch.clock_tenth    = '0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		typed_known          = 1'b0;
		typed_want           = '0;

		// reset values: zero preset, tenths
		add_item(FUNC_TICK,     0, 16'h1234, 6'd0,  6'd0,  4'd0,  1, 0, 16'h0000);
		add_item(FUNC_EVALUATE, 0, 16'hFFFF, 6'd59, 6'd59, 4'd9,  1, 0, 16'h0000);
		add_item(FUNC_EVALUATE, 1, 16'hFFFF, 6'd63, 6'd63, 4'd15, 1, 1, 16'h0000);
		add_item(FUNC_TICK,     0, 16'h0000, 6'd0,  6'd0,  4'd0,  1, 0, 16'h0000);
		add_cfg(16'hFFFF, UNIT_TENTHS);
		add_item(FUNC_EVALUATE, 1, 16'h0000, 6'd0,  6'd0,  4'd0,  1, 1, 16'h0000);
		add_item(FUNC_TICK,     0, 16'hFFFF, 6'd0,  6'd0,  4'd0,  1, 0, 16'hFFFF);
		add_item(FUNC_EVALUATE, 1, 16'h0000, 6'd0,  6'd0,  4'd0,  1, 1, 16'h0000);
		add_item(FUNC_TICK,     0, 16'h8000, 6'd0,  6'd0,  4'd0,  1, 1, 16'h8000);
		// sum overflows and saturates
		add_item(FUNC_TICK,     0, 16'h8001, 6'd0,  6'd0,  4'd0,  1, 0, 16'hFFFF);
		add_item(FUNC_EVALUATE, 1, 16'h0000, 6'd0,  6'd0,  4'd0,  1, 1, 16'h0000);
		add_item(FUNC_EVALUATE, 1, 16'h0000, 6'd0,  6'd0,  4'd0,  0, 0, 16'h0000);
		// seconds, compared against the snapshot left by reset
		add_cfg(16'd100, UNIT_SECONDS);
		add_item(FUNC_TICK,     0, 16'd5,    6'd17, 6'd42, 4'd0,  0, 0, 16'h0000);
		add_item(FUNC_TICK,     0, 16'd5,    6'd17, 6'd42, 4'd3,  0, 0, 16'h0000);
		add_item(FUNC_TICK,     1, 16'd5,    6'd12, 6'd34, 4'd7,  0, 0, 16'h0000);
		add_item(FUNC_TICK,     0, 16'd10,   6'd1,  6'd2,  4'd7,  0, 0, 16'h0000);
		add_cfg(16'd100, UNIT_MINUTES);
		add_item(FUNC_TICK,     0, 16'd10,   6'd5,  6'd34, 4'd7,  0, 0, 16'h0000);
		add_item(FUNC_TICK,     0, 16'd10,   6'd5,  6'd35, 4'd7,  0, 0, 16'h0000);
		add_cfg(16'd100, UNIT_HOURS);
		add_item(FUNC_TICK,     0, 16'd10,   6'd5,  6'd34, 4'd7,  0, 0, 16'h0000);
		add_item(FUNC_TICK,     0, 16'd200,  6'd12, 6'd34, 4'd7,  0, 0, 16'h0000);
		// clock fields beyond their range, compared bit for bit
		add_item(FUNC_EVALUATE, 1, 16'h0000, 6'd0,  6'd0,  4'd0,  0, 0, 16'h0000);
		add_item(FUNC_TICK,     1, 16'h0000, 6'd63, 6'd63, 4'd15, 0, 0, 16'h0000);
		add_item(FUNC_TICK,     0, 16'd1,    6'd63, 6'd63, 4'd15, 0, 0, 16'h0000);
		add_item(FUNC_TICK,     0, 16'hFFFF, 6'd63, 6'd63, 4'd15, 1, 0, 16'hFFFF);
		add_item(FUNC_TICK,     1, 16'hFFFF, 6'd63, 6'd63, 4'd15, 0, 0, 16'h0000);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				apply_cfg(dir_rows[i].preset, dir_rows[i].unit);
			end else begin
				send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
				dir_items++;
			end
		end

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0:       pr = '0;
				1:       pr = '1;
				5:       pr = count_t'($urandom);
				default: pr = count_t'($urandom_range(1, 400));
			endcase
			apply_cfg(pr, unit_t'(phase % 4));
			// one whole phase without gaps or stalls on either side
			calm = (phase == 4);
			repeat (PHASE_ITEMS)
				send_item(next_random_item(), 1'b0, '0);
		end
		calm = 1'b0;

		wait_drain();
		repeat (8) @(posedge clk);
		$display("covered %0d items (%0d from the corner-case table), %0d results checked",
		         items_sent, dir_items, results_seen);
		$display("%0d register writes over all four units and presets 0 to 65535, %0d mismatches",
		         reg_writes, mismatches);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("retriggerable_off_delay_timer_core_test: done, clean");
		else
			$display("retriggerable_off_delay_timer_core_test: done, errors");
		$finish;
	end

endmodule
